// ===== rtl/occ_pkg.sv =====
// Shared constants, action codes and control types for the occupancy grid core.
`timescale 1ns / 1ps
`default_nettype none
package occ_pkg;

   // Grid dimensions (defaults for the top-level parameters)
   localparam int DEF_GRID_WIDTH  = 64;
   localparam int DEF_GRID_HEIGHT = 64;
   localparam int DEF_GRID_LAYERS = 4;

   // Request action codes
   localparam logic [2:0] ACT_UPDATE  = 3'd0;
   localparam logic [2:0] ACT_ADVANCE = 3'd1;
   localparam logic [2:0] ACT_SET_AGE = 3'd2;
   localparam logic [2:0] ACT_READ    = 3'd3;
   localparam logic [2:0] ACT_FILL    = 3'd4;

   // Configuration register indexes
   localparam logic CSR_RECENT_WINDOW  = 1'b0;
   localparam logic CSR_CERTAINTY_STEP = 1'b1;

   // Cell and age constants
   localparam logic [4:0] AGE_WRAP     = 5'd31;
   localparam logic [2:0] CERT_MAX     = 3'd7;
   localparam logic [4:0] WINDOW_RESET = 5'd13;
   localparam logic [2:0] STEP_RESET   = 3'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;     // latch request fields, issue cell read
      logic exec;        // finish a non-fill transaction and respond
      logic sweep;       // write one cell of the sweep
      logic sweep_zero;  // sweep writes zero (reset clear) instead of fill byte
      logic fill_done;   // respond to a completed fill
   } occ_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic sweep_last;  // sweep counter sits at the last cell
   } occ_stat_type;

endpackage
`default_nettype wire

// ===== rtl/occ_ctrl.sv =====
// Controller state machine: sequences clear, fill sweeps and cell transactions.
`timescale 1ns / 1ps
`default_nettype none
module occ_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [2:0]         req_action,
   input  var  occ_pkg::occ_stat_type stat,
   output var  occ_pkg::occ_cmd_type  cmd,
   output logic                    busy
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_FILL
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   // Decode commands and next state
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.sweep      = 1'b1;
            cmd.sweep_zero = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = (req_action == occ_pkg::ACT_FILL) ? ST_FILL : ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_IDLE;
         end
         ST_FILL: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               cmd.fill_done = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   // Hold state and busy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

   // Accepted transaction keeps the block busy for the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> busy_ff)
      else $error("accepted transaction did not raise busy");

   // Clear and fill sweeps never report idle
   a_sweep_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR || state_ff == ST_FILL) |-> busy_ff)
      else $error("busy low during a sweep");

   // Only one command group is active at a time
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.exec, cmd.sweep}))
      else $error("conflicting datapath commands");

endmodule
`default_nettype wire

// ===== rtl/occ_dp.sv =====
// Datapath: cell memory, sweep counter, certainty update, scan age and response registers.
`timescale 1ns / 1ps
`default_nettype none
module occ_dp #(
   parameter int GRID_WIDTH  = occ_pkg::DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = occ_pkg::DEF_GRID_HEIGHT,
   parameter int GRID_LAYERS = occ_pkg::DEF_GRID_LAYERS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  var  occ_pkg::occ_cmd_type  cmd,
   output var  occ_pkg::occ_stat_type stat,
   input  wire logic [2:0]         req_action,
   input  wire logic [5:0]         req_cell_x,
   input  wire logic [5:0]         req_cell_y,
   input  wire logic [1:0]         req_layer,
   input  wire logic               req_obstacle,
   input  wire logic [4:0]         req_new_age,
   input  wire logic [7:0]         req_fill_byte,
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [4:0]         csr_wdata,
   output logic                    rsp_valid,
   output logic                    rsp_notify,
   output logic [5:0]              rsp_out_x,
   output logic [5:0]              rsp_out_y,
   output logic [7:0]              rsp_level,
   output logic [4:0]              rsp_scan_age
);

   localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT * GRID_LAYERS;
   localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

   // Cell memory and read register
   logic [7:0]        cell_mem_ff [CELL_COUNT];
   logic [7:0]        rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;

   // Request capture
   logic [2:0]        action_ff;
   logic [5:0]        x_ff, y_ff;
   logic              obstacle_ff;
   logic [4:0]        new_age_ff;
   logic [7:0]        fill_byte_ff;
   logic              in_range_ff;
   logic [ADDR_W-1:0] addr_ff;

   // Control registers
   logic [4:0]        window_ff;
   logic [2:0]        step_ff;
   logic [4:0]        age_ff, age_in;
   logic [ADDR_W-1:0] sweep_ff;

   // Response registers
   logic              valid_ff, valid_in;
   logic              notify_ff, notify_in;
   logic [5:0]        ox_ff, ox_in, oy_ff, oy_in;
   logic [7:0]        level_ff, level_in;
   logic [4:0]        scan_ff;

   // Address of the incoming request
   logic [31:0]       idx_wide;
   logic [ADDR_W-1:0] rd_addr;
   logic              req_in_range;

   assign idx_wide = (32'(req_layer) * 32'(GRID_HEIGHT) + 32'(req_cell_y)) * 32'(GRID_WIDTH)
                     + 32'(req_cell_x);
   assign rd_addr  = idx_wide[ADDR_W-1:0];
   assign req_in_range = (32'(req_cell_x) < 32'(GRID_WIDTH)) &&
                         (32'(req_cell_y) < 32'(GRID_HEIGHT)) &&
                         (32'(req_layer) < 32'(GRID_LAYERS));

   // Certainty update of the fetched cell
   logic [4:0] cell_age;
   logic [2:0] prob;
   logic [5:0] diff;
   logic [3:0] raised;
   logic [2:0] next_cert;

   always_comb begin
      cell_age = rd_data_ff[7:3];
      prob     = rd_data_ff[2:0];
      if (age_ff > cell_age) begin
         diff = {1'b0, age_ff} - {1'b0, cell_age};
      end else begin
         diff = {1'b0, age_ff} + {1'b0, occ_pkg::AGE_WRAP} - {1'b0, cell_age};
      end
      if (cell_age == 5'd0) begin
         diff = {1'b0, occ_pkg::AGE_WRAP};
      end
      raised = {1'b0, prob} + {1'b0, step_ff};
      if (!obstacle_ff) begin
         next_cert = (prob > step_ff) ? (prob - step_ff) : 3'd0;
      end else if (prob == 3'd0 && diff < {1'b0, window_ff}) begin
         next_cert = 3'd0;
      end else if (raised > {1'b0, occ_pkg::CERT_MAX}) begin
         next_cert = occ_pkg::CERT_MAX;
      end else begin
         next_cert = raised[2:0];
      end
   end

   // Execute a captured transaction or a sweep write and build the response
   always_comb begin
      age_in    = age_ff;
      valid_in  = cmd.exec || cmd.fill_done;
      notify_in = 1'b0;
      ox_in     = 6'd0;
      oy_in     = 6'd0;
      level_in  = 8'd0;
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = {age_ff, next_cert};
      if (cmd.sweep) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_ff;
         mem_wdata = cmd.sweep_zero ? 8'd0 : fill_byte_ff;
      end else if (cmd.exec) begin
         case (action_ff)
            occ_pkg::ACT_UPDATE: begin
               ox_in = x_ff;
               oy_in = y_ff;
               if (in_range_ff) begin
                  mem_we    = 1'b1;
                  notify_in = 1'b1;
                  level_in  = (next_cert == 3'd0) ? 8'd0 : {next_cert, 5'b11111};
               end
            end
            occ_pkg::ACT_ADVANCE: begin
               age_in = (age_ff >= occ_pkg::AGE_WRAP) ? 5'd1 : age_ff + 5'd1;
            end
            occ_pkg::ACT_SET_AGE: begin
               age_in = new_age_ff;
            end
            occ_pkg::ACT_READ: begin
               ox_in = x_ff;
               oy_in = y_ff;
               if (in_range_ff) begin
                  level_in = {prob, 5'b00000};
               end
            end
            default: begin
               age_in = age_ff;
            end
         endcase
      end
   end

   // Write and read the cell memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= cell_mem_ff[rd_addr];
   end

   // Latch request fields on accept
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff    <= req_action;
         x_ff         <= req_cell_x;
         y_ff         <= req_cell_y;
         obstacle_ff  <= req_obstacle;
         new_age_ff   <= req_new_age;
         fill_byte_ff <= req_fill_byte;
         in_range_ff  <= req_in_range;
         addr_ff      <= rd_addr;
      end
   end

   // Advance the sweep counter, wrap at the last cell
   assign stat.sweep_last = (sweep_ff == ADDR_W'(CELL_COUNT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.sweep) begin
         sweep_ff <= stat.sweep_last ? '0 : sweep_ff + ADDR_W'(1);
      end
   end

   // Hold configuration and scan age
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= occ_pkg::WINDOW_RESET;
         step_ff   <= occ_pkg::STEP_RESET;
         age_ff    <= 5'd0;
      end else begin
         age_ff <= age_in;
         if (csr_we && csr_index == occ_pkg::CSR_RECENT_WINDOW) begin
            window_ff <= csr_wdata;
         end
         if (csr_we && csr_index == occ_pkg::CSR_CERTAINTY_STEP) begin
            step_ff <= csr_wdata[2:0];
         end
      end
   end

   // Register the response
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (valid_in) begin
         notify_ff <= notify_in;
         ox_ff     <= ox_in;
         oy_ff     <= oy_in;
         level_ff  <= level_in;
         scan_ff   <= age_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_notify   = notify_ff;
   assign rsp_out_x    = ox_ff;
   assign rsp_out_y    = oy_ff;
   assign rsp_level    = level_ff;
   assign rsp_scan_age = scan_ff;

   // A response is never followed directly by another
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      valid_ff |=> !valid_ff)
      else $error("back-to-back responses");

   // Reported scan age matches the live age register
   a_rsp_age: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (scan_ff == age_ff))
      else $error("response scan age differs from current age");

   // A notify only comes with a nonzero odd-filled or zero level of an update
   a_notify_level: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && notify_ff) |-> (level_ff == 8'd0 || level_ff[4:0] == 5'b11111))
      else $error("update level malformed");

endmodule
`default_nettype wire

// ===== rtl/occupancy_grid_cell_update_core.sv =====
// Top level of the occupancy grid cell update core: controller plus datapath.
//
//   channel   ports                                   handshake
//   request   start, busy, req_*                      taken when start && !busy
//   response  rsp_valid, rsp_*                        one-cycle strobe, no backpressure
//   config    csr_we, csr_index, csr_wdata            written when csr_we is high
//
// Update, read, advance and set-age transactions fetch the cell from the
// single-port-write memory as the request is taken, then modify, write back and
// respond in the execute state; the response strobes in the cycle after, when
// busy is already low. Fill walks the memory one cell per cycle over all
// GRID_WIDTH*GRID_HEIGHT*GRID_LAYERS cells (16384 at defaults), then the response.
// After reset the same sweep clears every cell to zero; busy stays high until
// the clear is done. Configuration writes are taken at any time.
// The receiver cannot stall the response.
`timescale 1ns / 1ps
`default_nettype none
module occupancy_grid_cell_update_core #(
   parameter int GRID_WIDTH  = occ_pkg::DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = occ_pkg::DEF_GRID_HEIGHT,
   parameter int GRID_LAYERS = occ_pkg::DEF_GRID_LAYERS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [2:0] req_action,
   input  wire logic [5:0] req_cell_x,
   input  wire logic [5:0] req_cell_y,
   input  wire logic [1:0] req_layer,
   input  wire logic       req_obstacle,
   input  wire logic [4:0] req_new_age,
   input  wire logic [7:0] req_fill_byte,
   output logic            rsp_valid,
   output logic            rsp_notify,
   output logic [5:0]      rsp_out_x,
   output logic [5:0]      rsp_out_y,
   output logic [7:0]      rsp_level,
   output logic [4:0]      rsp_scan_age,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [4:0] csr_wdata
);

   occ_pkg::occ_cmd_type  cmd;
   occ_pkg::occ_stat_type stat;

   // Sequence transactions
   occ_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   // Store cells and compute responses
   occ_dp #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT),
      .GRID_LAYERS (GRID_LAYERS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_action    (req_action),
      .req_cell_x    (req_cell_x),
      .req_cell_y    (req_cell_y),
      .req_layer     (req_layer),
      .req_obstacle  (req_obstacle),
      .req_new_age   (req_new_age),
      .req_fill_byte (req_fill_byte),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_notify    (rsp_notify),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_level     (rsp_level),
      .rsp_scan_age  (rsp_scan_age)
   );

endmodule
`default_nettype wire

// ===== verif/occupancy_grid_cell_update_core_tb.sv =====
// Self-checking testbench for the occupancy grid cell update core.
`timescale 1ns / 1ps
`default_nettype none
module occupancy_grid_cell_update_core_tb;

   localparam int CELL_TOTAL = occ_pkg::DEF_GRID_WIDTH * occ_pkg::DEF_GRID_HEIGHT *
                               occ_pkg::DEF_GRID_LAYERS;
   localparam logic [2:0] ACT_SPARE_LO = 3'd5;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;
   localparam int HOT_CELLS = 8;

   typedef struct packed {
      logic [2:0] action;
      logic [5:0] cell_x;
      logic [5:0] cell_y;
      logic [1:0] layer;
      logic       obstacle;
      logic [4:0] new_age;
      logic [7:0] fill_byte;
   } cell_req_type;

   typedef struct packed {
      logic       notify;
      logic [5:0] out_x;
      logic [5:0] out_y;
      logic [7:0] level;
      logic [4:0] scan_age;
   } cell_rsp_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [2:0] req_action;
   logic [5:0] req_cell_x;
   logic [5:0] req_cell_y;
   logic [1:0] req_layer;
   logic       req_obstacle;
   logic [4:0] req_new_age;
   logic [7:0] req_fill_byte;
   logic       rsp_valid;
   logic       rsp_notify;
   logic [5:0] rsp_out_x;
   logic [5:0] rsp_out_y;
   logic [7:0] rsp_level;
   logic [4:0] rsp_scan_age;
   logic       csr_we;
   logic       csr_index;
   logic [4:0] csr_wdata;

   // Shadow copy of the grid, the scan age and the registers
   logic [7:0] grid_cells [CELL_TOTAL];
   logic [4:0] grid_age;
   logic [4:0] window_reg;
   logic [2:0] step_reg;

   cell_rsp_type cell_reports_q [$];
   int         mismatch_count;
   int         sender_idle_pct;
   int         fills_left;
   logic [5:0] hot_x [HOT_CELLS];
   logic [5:0] hot_y [HOT_CELLS];
   logic [1:0] hot_l [HOT_CELLS];

   occupancy_grid_cell_update_core uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_action    (req_action),
      .req_cell_x    (req_cell_x),
      .req_cell_y    (req_cell_y),
      .req_layer     (req_layer),
      .req_obstacle  (req_obstacle),
      .req_new_age   (req_new_age),
      .req_fill_byte (req_fill_byte),
      .rsp_valid     (rsp_valid),
      .rsp_notify    (rsp_notify),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_level     (rsp_level),
      .rsp_scan_age  (rsp_scan_age),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Stop a hung run
   initial begin
      #15_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: MISMATCH %s", $time, msg);
      mismatch_count++;
   endtask

   // Apply one transaction to the shadow grid and return the expected report
   function automatic cell_rsp_type grid_step(input cell_req_type r);
      cell_rsp_type o;
      int         idx;
      int         age_gap;
      int         sum;
      logic [2:0] cert;
      logic [2:0] next_cert;
      logic [4:0] cell_age;
      o = '0;
      idx = (int'(r.layer) * occ_pkg::DEF_GRID_HEIGHT + int'(r.cell_y)) *
            occ_pkg::DEF_GRID_WIDTH + int'(r.cell_x);
      case (r.action)
         occ_pkg::ACT_UPDATE: begin
            o.out_x = r.cell_x;
            o.out_y = r.cell_y;
            cert = grid_cells[idx][2:0];
            cell_age = grid_cells[idx][7:3];
            if (grid_age > cell_age)
               age_gap = int'(grid_age) - int'(cell_age);
            else
               age_gap = int'(grid_age) + int'(occ_pkg::AGE_WRAP) - int'(cell_age);
            // never-stamped cells count as old
            if (cell_age == 5'd0)
               age_gap = int'(occ_pkg::AGE_WRAP);
            if (!r.obstacle) begin
               next_cert = (cert > step_reg) ? cert - step_reg : 3'd0;
            end else if (cert == 3'd0 && age_gap < int'(window_reg)) begin
               next_cert = 3'd0;
            end else begin
               sum = int'(cert) + int'(step_reg);
               next_cert = (sum > int'(occ_pkg::CERT_MAX)) ? occ_pkg::CERT_MAX : 3'(sum);
            end
            grid_cells[idx] = {grid_age, next_cert};
            o.notify = 1'b1;
            o.level = (next_cert == 3'd0) ? 8'd0 : {next_cert, 5'd31};
         end
         occ_pkg::ACT_ADVANCE: begin
            grid_age = (grid_age >= occ_pkg::AGE_WRAP) ? 5'd1 : grid_age + 5'd1;
         end
         occ_pkg::ACT_SET_AGE: begin
            grid_age = r.new_age;
         end
         occ_pkg::ACT_READ: begin
            o.out_x = r.cell_x;
            o.out_y = r.cell_y;
            o.level = {grid_cells[idx][2:0], 5'd0};
         end
         occ_pkg::ACT_FILL: begin
            foreach (grid_cells[i])
               grid_cells[i] = r.fill_byte;
         end
         default: ;
      endcase
      o.scan_age = grid_age;
      return o;
   endfunction

   // Lower start for a number of cycles
   task automatic hold_off(input int cycles);
      @(negedge clock);
      start = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Drive one transaction, wait for it to be taken, queue its report
   task automatic send_item(input cell_req_type r);
      @(negedge clock);
      start = 1'b1;
      req_action = r.action;
      req_cell_x = r.cell_x;
      req_cell_y = r.cell_y;
      req_layer = r.layer;
      req_obstacle = r.obstacle;
      req_new_age = r.new_age;
      req_fill_byte = r.fill_byte;
      @(posedge clock);
      while (busy) @(posedge clock);
      cell_reports_q.push_back(grid_step(r));
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
         hold_off($urandom_range(1, 6));
   endtask

   // Drain all outstanding reports before touching the registers
   task automatic quiesce();
      @(negedge clock);
      start = 1'b0;
      while (cell_reports_q.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [4:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      if (idx == occ_pkg::CSR_RECENT_WINDOW)
         window_reg = value;
      else
         step_reg = value[2:0];
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic cell_req_type make_req(input logic [2:0] act, input int x, input int y,
                                             input int l, input logic obs, input int age,
                                             input int fill);
      cell_req_type r;
      r.action = act;
      r.cell_x = 6'(x);
      r.cell_y = 6'(y);
      r.layer = 2'(l);
      r.obstacle = obs;
      r.new_age = 5'(age);
      r.fill_byte = 8'(fill);
      return r;
   endfunction

   // Random transaction: mostly updates and reads on a few hot cells so that
   // certainty climbs and falls, with age moves, spare codes and rare fills
   function automatic cell_req_type random_req();
      cell_req_type r;
      int        roll;
      int        pick;
      r = 31'($urandom);
      if ($urandom_range(99) < 70) begin
         pick = $urandom_range(HOT_CELLS - 1);
         r.cell_x = hot_x[pick];
         r.cell_y = hot_y[pick];
         r.layer = hot_l[pick];
      end
      roll = $urandom_range(999);
      if (roll < 8 && fills_left > 0) begin
         r.action = occ_pkg::ACT_FILL;
         fills_left--;
      end else if (roll < 490)
         r.action = occ_pkg::ACT_UPDATE;
      else if (roll < 690)
         r.action = occ_pkg::ACT_READ;
      else if (roll < 810)
         r.action = occ_pkg::ACT_ADVANCE;
      else if (roll < 890)
         r.action = occ_pkg::ACT_SET_AGE;
      else if (roll < 930)
         r.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      else
         r.action = occ_pkg::ACT_UPDATE;
      return r;
   endfunction

   task automatic run_random(input int count);
      repeat (count) send_item(random_req());
   endtask

   // Cleared grid, age wrap, recent-empty rule, saturation, spare codes, fill
   task automatic test_directed();
      sender_idle_pct = 35;
      send_item(make_req(occ_pkg::ACT_READ, 0, 0, 0, 1'b0, 0, 0));
      send_item(make_req(occ_pkg::ACT_READ, 63, 63, 3, 1'b1, 31, 255));
      send_item(make_req(occ_pkg::ACT_UPDATE, 0, 0, 0, 1'b1, 0, 0));
      send_item(make_req(occ_pkg::ACT_ADVANCE, 0, 0, 0, 1'b0, 0, 0));
      send_item(make_req(occ_pkg::ACT_SET_AGE, 0, 0, 0, 1'b0, 31, 0));
      send_item(make_req(occ_pkg::ACT_ADVANCE, 0, 0, 0, 1'b0, 0, 0));
      send_item(make_req(occ_pkg::ACT_ADVANCE, 0, 0, 0, 1'b0, 0, 0));
      send_item(make_req(occ_pkg::ACT_UPDATE, 63, 63, 3, 1'b0, 0, 0));
      send_item(make_req(occ_pkg::ACT_SET_AGE, 0, 0, 0, 1'b0, 6, 0));
      // empty cell seen four scans ago ignores the obstacle hit
      send_item(make_req(occ_pkg::ACT_UPDATE, 63, 63, 3, 1'b1, 0, 0));
      send_item(make_req(occ_pkg::ACT_SET_AGE, 0, 0, 0, 1'b0, 20, 0));
      repeat (4) send_item(make_req(occ_pkg::ACT_UPDATE, 63, 63, 3, 1'b1, 0, 0));
      send_item(make_req(occ_pkg::ACT_READ, 63, 63, 3, 1'b0, 0, 0));
      // free hits down to zero
      repeat (4) send_item(make_req(occ_pkg::ACT_UPDATE, 63, 63, 3, 1'b0, 0, 0));
      send_item(make_req(ACT_SPARE_LO, 9, 9, 1, 1'b1, 3, 3));
      send_item(make_req(ACT_SPARE_HI, 63, 63, 3, 1'b1, 31, 255));
      send_item(make_req(occ_pkg::ACT_FILL, 0, 0, 0, 1'b0, 0, 255));
      send_item(make_req(occ_pkg::ACT_READ, 17, 42, 1, 1'b0, 0, 0));
      send_item(make_req(occ_pkg::ACT_UPDATE, 17, 42, 1, 1'b0, 0, 0));
      send_item(make_req(occ_pkg::ACT_FILL, 0, 0, 0, 1'b0, 0, 0));
      quiesce();
   endtask

   // Walk the register extremes, including a zero step
   task automatic test_register_settings();
      logic [4:0] windows [4];
      logic [4:0] steps [4];
      windows = '{5'd0, 5'd31, 5'd5, occ_pkg::WINDOW_RESET};
      steps = '{5'd1, 5'd7, 5'd0, 5'(occ_pkg::STEP_RESET)};
      sender_idle_pct = 20;
      foreach (windows[i]) begin
         write_csr(occ_pkg::CSR_RECENT_WINDOW, windows[i]);
         write_csr(occ_pkg::CSR_CERTAINTY_STEP, steps[i]);
         fills_left = 1;
         run_random(60);
         quiesce();
      end
   endtask

   // Random traffic under one sender idle profile and a random register setting
   task automatic test_random_phase(input int idle_pct, input int count);
      write_csr(occ_pkg::CSR_RECENT_WINDOW, 5'($urandom_range(31)));
      write_csr(occ_pkg::CSR_CERTAINTY_STEP, 5'($urandom_range(7)));
      sender_idle_pct = idle_pct;
      fills_left = 2;
      run_random(count);
      quiesce();
   endtask

   // Compare each report with the oldest expectation
   always @(posedge clock) begin
      cell_rsp_type want;
      if (!reset && rsp_valid) begin
         if (cell_reports_q.size() == 0) begin
            report_mismatch("report with no transaction outstanding");
         end else begin
            want = cell_reports_q.pop_front();
            if (rsp_notify !== want.notify)
               report_mismatch($sformatf("notify got %0d want %0d", rsp_notify, want.notify));
            if (rsp_out_x !== want.out_x)
               report_mismatch($sformatf("out_x got %0d want %0d", rsp_out_x, want.out_x));
            if (rsp_out_y !== want.out_y)
               report_mismatch($sformatf("out_y got %0d want %0d", rsp_out_y, want.out_y));
            if (rsp_level !== want.level)
               report_mismatch($sformatf("level got %0d want %0d", rsp_level, want.level));
            if (rsp_scan_age !== want.scan_age)
               report_mismatch($sformatf("scan_age got %0d want %0d",
                                         rsp_scan_age, want.scan_age));
         end
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_action = occ_pkg::ACT_UPDATE;
      req_cell_x = '0;
      req_cell_y = '0;
      req_layer = '0;
      req_obstacle = 1'b0;
      req_new_age = '0;
      req_fill_byte = '0;
      csr_we = 1'b0;
      csr_index = occ_pkg::CSR_RECENT_WINDOW;
      csr_wdata = '0;
      mismatch_count = 0;
      sender_idle_pct = 0;
      fills_left = 0;
      foreach (grid_cells[i])
         grid_cells[i] = 8'd0;
      grid_age = 5'd0;
      window_reg = occ_pkg::WINDOW_RESET;
      step_reg = occ_pkg::STEP_RESET;
      hot_x = '{6'd0, 6'd63, 6'd0, 6'd63, 6'd31, 6'd32, 6'd5, 6'd58};
      hot_y = '{6'd0, 6'd63, 6'd63, 6'd0, 6'd32, 6'd31, 6'd44, 6'd13};
      hot_l = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_register_settings();
      test_random_phase(35, 280);
      test_random_phase(53, 280);
      test_random_phase(0, 280);

      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
`default_nettype wire
